FILE: design/arht_pkg.sv
package arht_pkg;

  localparam int Buckets = 1024;
  localparam int Entries = 1024;
  localparam int BucketBits = $clog2(Buckets);
  localparam int LinkBits = $clog2(Entries + 1);
  localparam int SlotBits = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int BucketCountBits = $clog2(Buckets + 1);
  localparam logic [LinkBits-1:0] NilLink = LinkBits'(Entries);

  typedef enum logic [1:0] {
    OP_RECORD  = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_SPARE   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_RECORDED  = 3'd0,
    ST_SKIPPED   = 3'd1,
    ST_RELEASED  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_CLEARED   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_REC_FREE,
    S_REC_HEAD,
    S_REL_HEAD,
    S_REL_READ,
    S_REL_CMP,
    S_REL_NEXT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       wr;
    logic [BucketBits-1:0] addr;
    logic [LinkBits-1:0]   data;
  } head_wr_t;

endpackage

FILE: design/arht_head_ram.sv
module arht_head_ram
  import arht_pkg::*;
(
  input  logic                  clk,
  input  arht_pkg::head_wr_t    wr,
  input  logic [BucketBits-1:0] rd_addr,
  output logic [LinkBits-1:0]   rd_data
);

  logic [LinkBits-1:0] mem [Buckets];

  always_ff @(posedge clk) begin
    if (wr.wr) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/address_record_hash_table_core.sv
// Channel | Direction | Signals
// in      | input     | in_valid, in_ready, opcode, address, block_size
// out     | output    | out_valid, out_ready, status, released_size, skipped_total, live_total
// Record passes through S_REC_FREE, S_REC_HEAD and S_DONE; a skipped record goes from S_REC_FREE to S_DONE.
// Release reads the bucket head in S_REL_HEAD, then walks S_REL_READ, S_REL_CMP, S_REL_NEXT per chain entry.
// The walk through the entry memory, one read port, sets the release time.
// Clear is a sweep over the bucket heads; reset runs it with no word out.
// No word is taken during the sweep.
// The result register holds while out_ready is low; no new word is taken until it is taken.
module address_record_hash_table_core
  import arht_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [63:0] address,
  input  logic [31:0] block_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] released_size,
  output logic [31:0] skipped_total,
  output logic [10:0] live_total
);

  state_t state, state_next;
  logic [BucketCountBits-1:0] sweep;
  logic [1:0]  op;
  logic [63:0] addr;
  logic [31:0] size;
  logic [BucketBits-1:0] bkt;
  logic [LinkBits-1:0] free_head, high_water, cur, prev, slot;
  logic [31:0] skipped;
  logic [10:0] live;

  logic [63:0] ea_mem [Entries];
  logic [31:0] es_mem [Entries];
  logic [LinkBits-1:0] el_mem [Entries];
  logic [63:0] ea_rd;
  logic [31:0] es_rd;
  logic [LinkBits-1:0] el_rd;
  logic [SlotBits-1:0] ent_rd_addr;

  head_wr_t hw;
  logic [LinkBits-1:0] head_rd;
  logic [BucketBits-1:0] head_rd_addr;

  assign head_rd_addr = (state == S_IDLE) ? address[BucketBits-1:0] : bkt;

  arht_head_ram u_head (
    .clk(clk), .wr(hw), .rd_addr(head_rd_addr), .rd_data(head_rd)
  );

  assign ent_rd_addr = (state == S_IDLE) ? free_head[SlotBits-1:0] : cur[SlotBits-1:0];

  logic ent_wr, ent_wr_full;
  logic [SlotBits-1:0] ent_wr_addr;
  logic [LinkBits-1:0] ent_wr_link;
  logic relink;

  always_ff @(posedge clk) begin
    ea_rd <= ea_mem[ent_rd_addr];
    es_rd <= es_mem[ent_rd_addr];
    el_rd <= el_mem[ent_rd_addr];
    if (ent_wr) begin
      el_mem[ent_wr_addr] <= ent_wr_link;
      if (ent_wr_full) begin
        ea_mem[ent_wr_addr] <= addr;
        es_mem[ent_wr_addr] <= size;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_SWEEP: begin
        if (sweep == BucketCountBits'(Buckets - 1)) begin
          state_next = (op == OP_RECORD) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          unique case (opcode_t'(opcode))
            OP_RECORD:  state_next = S_REC_FREE;
            OP_RELEASE: state_next = S_REL_HEAD;
            default:    state_next = S_SWEEP;
          endcase
        end
      end
      S_REC_FREE: state_next = (slot == NilLink) ? S_DONE : S_REC_HEAD;
      S_REC_HEAD: state_next = S_DONE;
      S_REL_HEAD: state_next = S_REL_READ;
      S_REL_READ: state_next = (cur == NilLink) ? S_DONE : S_REL_CMP;
      S_REL_CMP:  state_next = S_REL_NEXT;
      S_REL_NEXT: state_next = (ea_rd == addr) ? S_DONE : S_REL_READ;
      S_DONE:     if (out_ready || !out_valid) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    hw = '0;
    ent_wr = 1'b0;
    ent_wr_full = 1'b0;
    ent_wr_addr = slot[SlotBits-1:0];
    ent_wr_link = head_rd;
    unique case (state)
      S_SWEEP: begin
        hw.wr = 1'b1;
        hw.addr = sweep[BucketBits-1:0];
        hw.data = NilLink;
      end
      S_REC_HEAD: begin
        hw.wr = 1'b1; hw.addr = bkt; hw.data = cur;
        ent_wr = 1'b1; ent_wr_full = 1'b1;
        ent_wr_addr = cur[SlotBits-1:0];
      end
      S_REL_NEXT: begin
        if (ea_rd == addr) begin
          ent_wr = 1'b1;
          ent_wr_addr = cur[SlotBits-1:0];
          ent_wr_link = free_head;
          if (prev == NilLink) begin
            hw.wr = 1'b1; hw.addr = bkt; hw.data = el_rd;
          end
        end
      end
      S_DONE: begin
        if (relink) begin
          ent_wr = 1'b1;
          ent_wr_addr = prev[SlotBits-1:0];
          ent_wr_link = el_rd;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      op <= OP_RECORD;
      relink <= 1'b0;
      sweep <= '0;
      free_head <= NilLink;
      high_water <= '0;
      skipped <= '0;
      live <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      relink <= (state == S_REL_NEXT) && (ea_rd == addr) && (prev != NilLink);
      if (state == S_DONE && state_next == S_IDLE) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_SWEEP: begin
          sweep <= sweep + 1'b1;
          if (state_next == S_DONE) begin
            status <= ST_CLEARED;
            released_size <= '0;
            skipped_total <= skipped;
            live_total <= live;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op <= opcode;
            addr <= address;
            size <= block_size;
            bkt <= address[BucketBits-1:0];
            sweep <= '0;
            prev <= NilLink;
            if (opcode_t'(opcode) != OP_RECORD && opcode_t'(opcode) != OP_RELEASE) begin
              free_head <= NilLink;
              high_water <= '0;
              skipped <= '0;
              live <= '0;
            end
          end
        end
        S_REC_FREE: begin
          cur <= slot;
          if (slot == NilLink) begin
            skipped <= (skipped == '1) ? skipped : skipped + 1'b1;
            status <= ST_SKIPPED;
            skipped_total <= (skipped == '1) ? skipped : skipped + 1'b1;
            live_total <= live;
            released_size <= '0;
          end else if (free_head != NilLink) begin
            free_head <= el_rd;
          end else begin
            high_water <= high_water + 1'b1;
          end
        end
        S_REC_HEAD: begin
          live <= live + 1'b1;
          status <= ST_RECORDED;
          released_size <= '0;
          skipped_total <= skipped;
          live_total <= live + 1'b1;
        end
        S_REL_HEAD: cur <= head_rd;
        S_REL_READ: begin
          if (cur == NilLink) begin
            status <= ST_NOT_FOUND;
            released_size <= '0;
            skipped_total <= skipped;
            live_total <= live;
          end
        end
        S_REL_NEXT: begin
          if (ea_rd == addr) begin
            free_head <= cur;
            live <= (live != '0) ? live - 1'b1 : live;
            status <= ST_RELEASED;
            released_size <= es_rd;
            skipped_total <= skipped;
            live_total <= (live != '0) ? live - 1'b1 : live;
          end else begin
            prev <= cur;
            cur <= el_rd;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    slot = NilLink;
    if (free_head != NilLink) slot = free_head;
    else if (high_water != NilLink) slot = high_water;
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  ap_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  ap_live: assert property (@(posedge clk) disable iff (rst)
    live <= 11'(Entries)) else $error("live count overflow");
  ap_hw: assert property (@(posedge clk) disable iff (rst)
    high_water <= NilLink) else $error("high water overflow");

endmodule
